// ===== rtl/pod_pkg.sv =====
// ----------------------------------------------------------------------------
// pod_pkg
// Shared types and constants for the padded obstacle dilation block.
// ----------------------------------------------------------------------------
package pod_pkg;

   localparam int COORD_W    = 9;
   localparam int COLOR_W    = 8;
   localparam int OP_W       = 2;
   localparam int PAD_W      = 4;
   localparam int SIZE_W     = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_PUT   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PAD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   // Register reset values.
   localparam logic [PAD_W-1:0]  PAD_RESET  = 4'd4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic is_black;
      logic status;
   } rsp_type;

   // What an accepted request turns into.
   typedef enum logic [1:0] {
      JOB_NONE,
      JOB_CLEAR,
      JOB_PAINT,
      JOB_READ
   } job_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_PAINT_RD,
      ST_PAINT_WR,
      ST_READ_RD,
      ST_READ_GET,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;      // latch the accepted request
      logic zero_wr;   // write a white row and advance the sweep
      logic rd_issue;  // read the row at the sweep position
      logic paint_wr;  // write the row back with the square's span set
      logic capture;   // take the addressed canvas bit
      logic finish;    // move the result into the response register
   } cmd_type;

   typedef struct packed {
      job_type job;        // decode of the request on the input port
      logic    clear_last; // sweep is on the last canvas row
      logic    paint_last; // sweep is on the last row of the square
      logic    rsp_busy;   // response register holds a result not yet taken
   } stat_type;

endpackage

// ===== rtl/padded_obstacle_dilation.sv =====
// ----------------------------------------------------------------------------
// padded_obstacle_dilation
// Obstacle inflation for a map image on a one-bit padded canvas.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   pod_pkg::req_type (op, col, row, rgb)
//   rsp_      out        rsp_valid / rsp_ready   pod_pkg::rsp_type (is_black, status)
//   csr_      in         csr_valid / csr_ready   csr_index, csr_wdata
//
// The canvas is stored one row per RAM word, so a black put reads each
// painted row and writes it back with the span set, for the 2p+1 rows of the
// square. A read fetches the row word and then takes the addressed bit, a
// clear sweeps every canvas row to white, one row a cycle, and other requests
// go straight to the final step. After reset the block sweeps every canvas
// row to white, one row a cycle, with req_ready low.
// A finished result waits in the response register while the next request is
// taken; only when a new result is ready before the old one is taken does the
// block hold in its final step. Configuration writes are taken at any time.
//
module padded_obstacle_dilation #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_PAD    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pod_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pod_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pod_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pod_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // Commands from the sequencer and status back from the datapath.
   pod_pkg::cmd_type  cmd;
   pod_pkg::stat_type stat;

   pod_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, the canvas RAM and the
   // response register.
   pod_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_PAD    (MAX_PAD)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ===== rtl/pod_ram.sv =====
// ----------------------------------------------------------------------------
// pod_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pod_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pod_ctrl.sv =====
// ----------------------------------------------------------------------------
// pod_ctrl
// Sequencer: walks each request through clear, paint or read steps.
// ----------------------------------------------------------------------------
module pod_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pod_pkg::stat_type stat,
   output pod_pkg::cmd_type  cmd
);

   pod_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pod_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pod_pkg::ST_INIT: begin
            if (stat.clear_last) state_in = pod_pkg::ST_IDLE;
         end
         pod_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (stat.job)
                  pod_pkg::JOB_CLEAR: state_in = pod_pkg::ST_CLEAR;
                  pod_pkg::JOB_PAINT: state_in = pod_pkg::ST_PAINT_RD;
                  pod_pkg::JOB_READ:  state_in = pod_pkg::ST_READ_RD;
                  default:            state_in = pod_pkg::ST_DONE;
               endcase
            end
         end
         pod_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = pod_pkg::ST_DONE;
         end
         pod_pkg::ST_PAINT_RD: state_in = pod_pkg::ST_PAINT_WR;
         pod_pkg::ST_PAINT_WR: begin
            state_in = stat.paint_last ? pod_pkg::ST_DONE : pod_pkg::ST_PAINT_RD;
         end
         pod_pkg::ST_READ_RD:  state_in = pod_pkg::ST_READ_GET;
         pod_pkg::ST_READ_GET: state_in = pod_pkg::ST_DONE;
         pod_pkg::ST_DONE: begin
            if (!stat.rsp_busy) state_in = pod_pkg::ST_IDLE;
         end
         default: state_in = pod_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == pod_pkg::ST_IDLE);
      cmd.load     = (state_ff == pod_pkg::ST_IDLE) && req_valid;
      cmd.zero_wr  = (state_ff == pod_pkg::ST_INIT) || (state_ff == pod_pkg::ST_CLEAR);
      cmd.rd_issue = (state_ff == pod_pkg::ST_PAINT_RD) || (state_ff == pod_pkg::ST_READ_RD);
      cmd.paint_wr = (state_ff == pod_pkg::ST_PAINT_WR);
      cmd.capture  = (state_ff == pod_pkg::ST_READ_GET);
      cmd.finish   = (state_ff == pod_pkg::ST_DONE) && !stat.rsp_busy;
   end

endmodule

// ===== rtl/pod_dp.sv =====
// ----------------------------------------------------------------------------
// pod_dp
// Datapath: configuration registers, request decode, row sweep, canvas RAM
// and the response register.
// ----------------------------------------------------------------------------
module pod_dp #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_PAD    = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pod_pkg::req_type                 req_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pod_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pod_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output pod_pkg::rsp_type                 rsp_data,
   input  pod_pkg::cmd_type                 cmd,
   output pod_pkg::stat_type                stat
);

   localparam int COLS   = MAX_WIDTH + 2 * MAX_PAD;
   localparam int ROWS   = MAX_HEIGHT + 2 * MAX_PAD;
   localparam int RowAw  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ColIw  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int CalcW  = $clog2(COLS + ROWS + 512) + 1;
   localparam logic [COLS-1:0] Ones = '1;

   // Configuration.
   logic [pod_pkg::PAD_W-1:0]  pad_ff;
   logic [pod_pkg::SIZE_W-1:0] width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff    <= pod_pkg::PAD_RESET;
         width_ff  <= pod_pkg::SIZE_RESET;
         height_ff <= pod_pkg::SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pod_pkg::CSR_PAD:    pad_ff    <= csr_wdata[pod_pkg::PAD_W-1:0];
            pod_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[pod_pkg::SIZE_W-1:0];
            pod_pkg::CSR_HEIGHT: height_ff <= csr_wdata[pod_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes, limited to the canvas capacity.
   logic [CalcW-1:0] pad_x, w_x, h_x, pad_eff, w_eff, h_eff, two_p;
   logic [CalcW-1:0] col_x, row_x, end_x;
   logic             put_oob, read_oob, src_black, bad_req;
   pod_pkg::job_type job_dec;
   logic [COLS-1:0]  span, mask_in;

   always_comb begin
      pad_x   = CalcW'(pad_ff);
      w_x     = CalcW'(width_ff);
      h_x     = CalcW'(height_ff);
      pad_eff = (pad_x > CalcW'(MAX_PAD))    ? CalcW'(MAX_PAD)    : pad_x;
      w_eff   = (w_x   > CalcW'(MAX_WIDTH))  ? CalcW'(MAX_WIDTH)  : w_x;
      h_eff   = (h_x   > CalcW'(MAX_HEIGHT)) ? CalcW'(MAX_HEIGHT) : h_x;
      two_p   = pad_eff << 1;
      col_x   = CalcW'(req_data.col);
      row_x   = CalcW'(req_data.row);
      end_x   = row_x + two_p;

      put_oob   = (col_x >= w_eff) || (row_x >= h_eff);
      read_oob  = (col_x >= w_eff + two_p) || (row_x >= h_eff + two_p);
      src_black = (req_data.red == '0) && (req_data.green == '0) && (req_data.blue == '0);

      case (req_data.op)
         pod_pkg::OP_CLEAR: begin
            job_dec = pod_pkg::JOB_CLEAR;
            bad_req = 1'b0;
         end
         pod_pkg::OP_PUT: begin
            job_dec = (!put_oob && src_black) ? pod_pkg::JOB_PAINT : pod_pkg::JOB_NONE;
            bad_req = put_oob;
         end
         pod_pkg::OP_READ: begin
            job_dec = read_oob ? pod_pkg::JOB_NONE : pod_pkg::JOB_READ;
            bad_req = read_oob;
         end
         default: begin
            job_dec = pod_pkg::JOB_NONE;
            bad_req = 1'b1;
         end
      endcase

      // Columns col .. col+2p of the row word.
      span    = ~(Ones << (two_p + CalcW'(1)));
      mask_in = span << col_x;
   end

   assign stat.job = job_dec;

   // Work registers.
   logic [RowAw-1:0] row_ff, row_in;
   logic [RowAw-1:0] end_row_ff;
   logic [ColIw-1:0] col_ff;
   logic [COLS-1:0]  mask_ff;
   logic             status_ff, black_ff;
   logic [COLS-1:0]  rd_data, wr_data;

   assign stat.clear_last = (row_ff == RowAw'(ROWS - 1));
   assign stat.paint_last = (row_ff == end_row_ff);

   always_comb begin
      row_in = row_ff;
      if (cmd.load) begin
         row_in = (job_dec == pod_pkg::JOB_CLEAR) ? '0 : row_x[RowAw-1:0];
      end else if (cmd.zero_wr || cmd.paint_wr) begin
         row_in = (cmd.zero_wr && stat.clear_last) ? '0 : row_ff + RowAw'(1);
      end else if (cmd.finish) begin
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         end_row_ff <= end_x[RowAw-1:0];
         col_ff     <= col_x[ColIw-1:0];
         mask_ff    <= mask_in;
         status_ff  <= bad_req;
         black_ff   <= 1'b0;
      end else if (cmd.capture) begin
         black_ff   <= rd_data[col_ff];
      end
   end

   assign wr_data = cmd.zero_wr ? '0 : (rd_data | mask_ff);

   pod_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (cmd.zero_wr || cmd.paint_wr),
      .wr_addr (row_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (row_ff),
      .rd_data (rd_data)
   );

   // Response register.
   logic             rsp_valid_ff;
   pod_pkg::rsp_type rsp_ff;

   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.is_black <= black_ff;
         rsp_ff.status   <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
